// ===== rtl/drds_pkg.sv =====
// ----------------------------------------------------------------------------
// drds_pkg: shared types and constants of the diversity switch
// Holds the sequencer states, register indexes, divider request and response
// structs and the fixed field widths.
// ----------------------------------------------------------------------------
package drds_pkg;

    localparam int SAMPLE_W = 10;   // width of one strength reading
    localparam int PCT_W    = 18;   // width of a signed percentage
    localparam int DVD_W    = 18;   // divider dividend and quotient width
    localparam int DVS_W    = 10;   // divider divisor width
    localparam int DIV_STEPS = DVD_W / 2;  // two quotient bits per cycle
    localparam int STEP_W   = $clog2(DIV_STEPS);

    // Mode numbers as seen on the result channel.
    localparam logic [1:0] MODE_RX1       = 2'd1;
    localparam logic [1:0] MODE_RX2       = 2'd2;
    localparam logic [1:0] MODE_DIVERSITY = 2'd3;

    typedef enum logic [2:0] {
        REG_RX1_FLOOR   = 3'd0,
        REG_RX1_CEILING = 3'd1,
        REG_RX2_FLOOR   = 3'd2,
        REG_RX2_CEILING = 3'd3,
        REG_DEBOUNCE    = 3'd4,
        REG_INTERVAL    = 3'd5,
        REG_HYSTERESIS  = 3'd6,
        REG_CLIP        = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_VIDEO,
        S_MODE,
        S_LOAD,
        S_DIV,
        S_STORE,
        S_DECIDE,
        S_OUT
    } state_t;

    // Operations run through the shared divider, in this order.
    typedef enum logic [1:0] {
        OP_MEAN1 = 2'd0,
        OP_MEAN2 = 2'd1,
        OP_PCT1  = 2'd2,
        OP_PCT2  = 2'd3
    } op_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/drds_window.sv =====
// ----------------------------------------------------------------------------
// drds_window: moving-sum window of one receiver
// Keeps the last readings in a small memory with per-entry valid bits and
// maintains their running sum.
// ----------------------------------------------------------------------------
module drds_window
    import drds_pkg::*;
#(
    parameter int AVG_DEPTH = 10
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  update,
    input  logic [SAMPLE_W-1:0]                   sample,
    output logic [$clog2(AVG_DEPTH*1023+1)-1:0]   sum
);

    localparam int SUM_W  = $clog2(AVG_DEPTH*1023+1);
    localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(AVG_DEPTH - 1);

    logic [SAMPLE_W-1:0] mem [AVG_DEPTH];
    logic [SAMPLE_W-1:0] rd_reg;
    logic                rd_valid_reg;
    logic [AVG_DEPTH-1:0] valid_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_next;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [SAMPLE_W-1:0] oldest;

    // The read port follows the current slot every cycle; the slot moves only
    // on updates, a whole result sequence apart, so the oldest entry is ready.
    always_ff @(posedge aclk) begin
        if (update) begin
            mem[slot_reg] <= sample;
        end
        rd_reg <= mem[slot_reg];
    end

    assign oldest    = rd_valid_reg ? rd_reg : '0;
    assign slot_next = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
    assign sum_next  = SUM_W'(({1'b0, sum_reg} - {{(SUM_W+1-SAMPLE_W){1'b0}}, oldest})
                              + {{(SUM_W+1-SAMPLE_W){1'b0}}, sample});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            slot_reg     <= '0;
            sum_reg      <= '0;
        end else begin
            rd_valid_reg <= valid_reg[slot_reg];
            if (update) begin
                valid_reg[slot_reg] <= 1'b1;
                slot_reg            <= slot_next;
                sum_reg             <= sum_next;
            end
        end
    end

    assign sum = sum_reg;

endmodule

// ===== rtl/drds_div.sv =====
// ----------------------------------------------------------------------------
// drds_div: shared unsigned restoring divider
// Produces two quotient bits per cycle while busy; rsp.done marks the final step, and
// the quotient is ready once that step is registered.
// ----------------------------------------------------------------------------
module drds_div
    import drds_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    logic              busy_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DVD_W-1:0]  dvd_next;
    logic [DVS_W:0]    rem_reg;
    logic [DVS_W:0]    rem_next;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W+1:0]  trial1;
    logic [DVS_W+1:0]  trial2;
    logic [DVS_W:0]    rem1;
    logic              ge1;
    logic              ge2;

    // Two chained restoring steps; the partial remainder stays below twice
    // the divisor, so it fits one bit above the divisor width.
    always_comb begin
        trial1   = {rem_reg, dvd_reg[DVD_W-1]};
        ge1      = trial1 >= {2'b00, dvs_reg};
        rem1     = ge1 ? (DVS_W+1)'(trial1 - {2'b00, dvs_reg}) : trial1[DVS_W:0];
        trial2   = {rem1, dvd_reg[DVD_W-2]};
        ge2      = trial2 >= {2'b00, dvs_reg};
        rem_next = ge2 ? (DVS_W+1)'(trial2 - {2'b00, dvs_reg}) : trial2[DVS_W:0];
        dvd_next = {dvd_reg[DVD_W-3:0], ge1, ge2};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == STEP_LAST) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done     = busy_reg && (cnt_reg == STEP_LAST);
    assign rsp.quotient = dvd_reg;

endmodule

// ===== rtl/dual_receiver_rssi_diversity_switch.sv =====
// ----------------------------------------------------------------------------
// dual_receiver_rssi_diversity_switch: receiver choice from averaged strength
// Averages both strength readings, maps them to percentages, debounces the
// mode and video buttons and picks the active receiver.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  s_axis    in         two readings, two button levels, millisecond time
//  m_axis    out        receiver and video selects, mode, bar, percents, means
//  apb       in/out     eight configuration registers at byte address 4*i
//
// A result is loaded after its beat is taken in this order: the video and mode debounce
// states, four divisions (two means, two percentages) on the shared divider, each as
// load, divide and store states, then the decision and the output load. The next beat
// can be taken in the cycle after the load, so no beat is taken before the last result is loaded.
// Reset is synchronous and active low; it restores defaults and empties the windows.
// s_tready is high only while idle; only loading a new result waits for m_tready.
//
module dual_receiver_rssi_diversity_switch
    import drds_pkg::*;
#(
    parameter int AVG_DEPTH = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input beat, from bit 0: rx1_sample[9:0], rx2_sample[19:10],
    // mode_button_level[20], video_button_level[21], now_ms[53:22], zero pad.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,
    // Result beat, from bit 0: rx_select[0], video_select[1], mode_number[3:2],
    // diversity_led[4], level_bar[8:5], rx1_percent[26:9], rx2_percent[44:27],
    // rx1_mean[54:45], rx2_mean[64:55], zero pad.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SUM_W = $clog2(AVG_DEPTH*1023+1);

    // Configuration registers.
    logic [9:0]  rx1_floor_reg;
    logic [9:0]  rx1_ceiling_reg;
    logic [9:0]  rx2_floor_reg;
    logic [9:0]  rx2_ceiling_reg;
    logic [15:0] debounce_reg;
    logic [15:0] interval_reg;
    logic [6:0]  hysteresis_reg;
    logic        clip_reg;
    logic        cfg_write;

    // Captured input beat.
    logic [SAMPLE_W-1:0] rx1_sample_reg;
    logic [SAMPLE_W-1:0] rx2_sample_reg;
    logic                mode_level_reg;
    logic                video_level_reg;
    logic [31:0]         now_reg;

    // Control state that lives across beats.
    logic [1:0]  mode_reg;
    logic        video_sel_reg;
    logic        rx_sel_reg;
    logic [31:0] mode_press_reg;
    logic [31:0] video_press_reg;
    logic [31:0] decision_reg;

    // Working values of the current beat.
    state_t          state_reg;
    state_t          state_next;
    op_t             op_reg;
    logic [9:0]      mean1_reg;
    logic [9:0]      mean2_reg;
    logic signed [PCT_W-1:0] pct1_reg;
    logic signed [PCT_W-1:0] pct2_reg;
    logic [3:0]      bar_reg;
    logic            neg_reg;
    logic            den_zero_reg;

    // Output register.
    logic        m_tvalid_reg;
    logic [71:0] m_tdata_reg;

    logic [SUM_W-1:0] sum1;
    logic [SUM_W-1:0] sum2;
    logic             win_update;
    logic             out_free;
    logic             out_load;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx1_floor_reg   <= 10'd512;
            rx1_ceiling_reg <= 10'd1023;
            rx2_floor_reg   <= 10'd512;
            rx2_ceiling_reg <= 10'd1023;
            debounce_reg    <= 16'd250;
            interval_reg    <= 16'd2000;
            hysteresis_reg  <= 7'd1;
            clip_reg        <= 1'b0;
        end else if (cfg_write) begin
            case (cfg_idx_t'(paddr[4:2]))
                REG_RX1_FLOOR:   rx1_floor_reg   <= pwdata[9:0];
                REG_RX1_CEILING: rx1_ceiling_reg <= pwdata[9:0];
                REG_RX2_FLOOR:   rx2_floor_reg   <= pwdata[9:0];
                REG_RX2_CEILING: rx2_ceiling_reg <= pwdata[9:0];
                REG_DEBOUNCE:    debounce_reg    <= pwdata[15:0];
                REG_INTERVAL:    interval_reg    <= pwdata[15:0];
                REG_HYSTERESIS:  hysteresis_reg  <= pwdata[6:0];
                REG_CLIP:        clip_reg        <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx_t'(paddr[4:2]))
            REG_RX1_FLOOR:   prdata = {22'd0, rx1_floor_reg};
            REG_RX1_CEILING: prdata = {22'd0, rx1_ceiling_reg};
            REG_RX2_FLOOR:   prdata = {22'd0, rx2_floor_reg};
            REG_RX2_CEILING: prdata = {22'd0, rx2_ceiling_reg};
            REG_DEBOUNCE:    prdata = {16'd0, debounce_reg};
            REG_INTERVAL:    prdata = {16'd0, interval_reg};
            REG_HYSTERESIS:  prdata = {25'd0, hysteresis_reg};
            REG_CLIP:        prdata = {31'd0, clip_reg};
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (s_tvalid) state_next = S_VIDEO;
            S_VIDEO:  state_next = S_MODE;
            S_MODE:   state_next = S_LOAD;
            S_LOAD:   state_next = S_DIV;
            S_DIV:    if (div_rsp.done) state_next = S_STORE;
            S_STORE:  state_next = (op_reg == OP_PCT2) ? S_DECIDE : S_LOAD;
            S_DECIDE: state_next = S_OUT;
            S_OUT:    if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = (state_reg == S_IDLE);
        win_update = (state_reg == S_VIDEO);
        out_load   = (state_reg == S_OUT) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Averaging windows
    // ------------------------------------------------------------------
    drds_window #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_win1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .update  (win_update),
        .sample  (rx1_sample_reg),
        .sum     (sum1)
    );

    drds_window #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_win2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .update  (win_update),
        .sample  (rx2_sample_reg),
        .sum     (sum2)
    );

    // ------------------------------------------------------------------
    // Elapsed-time compare, shared by both debounce checks and the
    // diversity interval check. Differences wrap modulo 2^32.
    // ------------------------------------------------------------------
    logic [31:0] cmp_ref;
    logic [15:0] cmp_lim;
    logic [31:0] elapsed;
    logic        elapsed_gt;

    always_comb begin
        case (state_reg)
            S_VIDEO: begin
                cmp_ref = video_press_reg;
                cmp_lim = debounce_reg;
            end
            S_MODE: begin
                cmp_ref = mode_press_reg;
                cmp_lim = debounce_reg;
            end
            default: begin
                cmp_ref = decision_reg;
                cmp_lim = interval_reg;
            end
        endcase
        elapsed    = now_reg - cmp_ref;
        elapsed_gt = elapsed > {16'd0, cmp_lim};
    end

    // ------------------------------------------------------------------
    // Divider operands. The means divide a window sum by the depth; the
    // percentages divide |(mean - floor) * 100| by |ceiling - floor| and the
    // sign is put back afterwards, which truncates toward zero.
    // ------------------------------------------------------------------
    logic [9:0]        map_mean;
    logic [9:0]        map_lo;
    logic [9:0]        map_hi;
    logic signed [10:0] delta;
    logic signed [10:0] span;
    logic [10:0]       delta_abs;
    logic [10:0]       span_abs;
    logic [16:0]       num_abs;

    always_comb begin
        map_mean  = op_reg[0] ? mean2_reg : mean1_reg;
        map_lo    = op_reg[0] ? rx2_floor_reg : rx1_floor_reg;
        map_hi    = op_reg[0] ? rx2_ceiling_reg : rx1_ceiling_reg;
        delta     = signed'({1'b0, map_mean}) - signed'({1'b0, map_lo});
        span      = signed'({1'b0, map_hi}) - signed'({1'b0, map_lo});
        delta_abs = delta[10] ? 11'(-delta) : 11'(delta);
        span_abs  = span[10] ? 11'(-span) : 11'(span);
        // Times one hundred as 64 + 32 + 4.
        num_abs   = (17'(delta_abs[9:0]) << 6) + (17'(delta_abs[9:0]) << 5)
                  + (17'(delta_abs[9:0]) << 2);

        div_req.start = (state_reg == S_LOAD);
        case (op_reg)
            OP_MEAN1: begin
                div_req.dividend = DVD_W'(sum1);
                div_req.divisor  = DVS_W'(AVG_DEPTH);
            end
            OP_MEAN2: begin
                div_req.dividend = DVD_W'(sum2);
                div_req.divisor  = DVS_W'(AVG_DEPTH);
            end
            default: begin
                div_req.dividend = DVD_W'(num_abs);
                div_req.divisor  = span_abs[9:0];
            end
        endcase
    end

    drds_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Percentage from the quotient: restore sign, add one, clip if enabled.
    // A zero span maps to zero before the one is added.
    logic signed [PCT_W-1:0] q_signed;
    logic signed [PCT_W-1:0] pct_raw;
    logic signed [PCT_W-1:0] pct_one;
    logic signed [PCT_W-1:0] pct_final;

    always_comb begin
        q_signed = signed'(div_rsp.quotient);
        if (den_zero_reg) begin
            pct_raw = '0;
        end else if (neg_reg) begin
            pct_raw = -q_signed;
        end else begin
            pct_raw = q_signed;
        end
        pct_one   = pct_raw + PCT_W'(1);
        pct_final = pct_one;
        if (clip_reg) begin
            if (pct_one < 0) begin
                pct_final = '0;
            end else if (pct_one > PCT_W'(100)) begin
                pct_final = PCT_W'(100);
            end
        end
    end

    // Level bar of the previously selected receiver and the hysteresis
    // comparison, both on the finished percentages.
    logic signed [PCT_W-1:0] bar_pct;
    logic signed [PCT_W:0]   p1_wide;
    logic signed [PCT_W:0]   p2_wide;
    logic signed [PCT_W:0]   hyst_wide;
    logic                    pick_rx1;
    logic                    pick_rx2;

    always_comb begin
        bar_pct   = rx_sel_reg ? pct2_reg : pct1_reg;
        p1_wide   = (PCT_W+1)'(pct1_reg);
        p2_wide   = (PCT_W+1)'(pct2_reg);
        hyst_wide = signed'((PCT_W+1)'(hysteresis_reg));
        pick_rx1  = (p1_wide + hyst_wide) > p2_wide;
        pick_rx2  = (p2_wide + hyst_wide) > p1_wide;
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_RX1;
            video_sel_reg   <= 1'b0;
            rx_sel_reg      <= 1'b0;
            mode_press_reg  <= '0;
            video_press_reg <= '0;
            decision_reg    <= '0;
            op_reg          <= OP_MEAN1;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    op_reg <= OP_MEAN1;
                end
                S_VIDEO: begin
                    if (!video_level_reg && elapsed_gt) begin
                        video_sel_reg   <= !video_sel_reg;
                        video_press_reg <= now_reg;
                    end
                end
                S_MODE: begin
                    if (!mode_level_reg && elapsed_gt) begin
                        mode_reg       <= (mode_reg == MODE_DIVERSITY) ? MODE_RX1
                                                                       : mode_reg + 2'd1;
                        mode_press_reg <= now_reg;
                    end
                end
                S_STORE: begin
                    op_reg <= op_t'(op_reg + 2'd1);
                end
                S_DECIDE: begin
                    case (mode_reg)
                        MODE_RX1: rx_sel_reg <= 1'b0;
                        MODE_RX2: rx_sel_reg <= 1'b1;
                        MODE_DIVERSITY: begin
                            if (elapsed_gt) begin
                                if (pick_rx1) begin
                                    rx_sel_reg <= 1'b0;
                                end else if (pick_rx2) begin
                                    rx_sel_reg <= 1'b1;
                                end
                                decision_reg <= now_reg;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            rx1_sample_reg  <= s_tdata[9:0];
            rx2_sample_reg  <= s_tdata[19:10];
            mode_level_reg  <= s_tdata[20];
            video_level_reg <= s_tdata[21];
            now_reg         <= s_tdata[53:22];
        end
        if (state_reg == S_LOAD) begin
            neg_reg      <= delta[10] ^ span[10];
            den_zero_reg <= (span == '0);
        end
        if (state_reg == S_STORE) begin
            case (op_reg)
                OP_MEAN1: mean1_reg <= div_rsp.quotient[9:0];
                OP_MEAN2: mean2_reg <= div_rsp.quotient[9:0];
                OP_PCT1:  pct1_reg  <= pct_final;
                OP_PCT2:  pct2_reg  <= pct_final;
                default: ;
            endcase
        end
        if (state_reg == S_DECIDE) begin
            bar_reg <= {bar_pct > PCT_W'(75), bar_pct > PCT_W'(50),
                        bar_pct > PCT_W'(25), bar_pct > 0};
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {7'd0, mean2_reg, mean1_reg, pct2_reg, pct1_reg, bar_reg,
                            mode_reg == MODE_DIVERSITY, mode_reg, video_sel_reg,
                            rx_sel_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
